@@ hw/rtl/mcic_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcic_pkg
// Shared types, codes and constants of the irrigation controller core.
// ----------------------------------------------------------------------------
package mcic_pkg;

  localparam int CHANNELS_DEF = 5;
  localparam int WINDOW_DEF   = 15;

  localparam logic [9:0] WET_RAW_RST  = 10'd920;
  localparam logic [9:0] DRY_RAW_RST  = 10'd175;
  localparam logic [7:0] COOLDOWN_RST = 8'd30;
  localparam logic [3:0] LIMIT_RST    = 4'd5;
  localparam logic [9:0] MOIST_RST    = 10'd50;
  localparam logic [6:0] THR_RST      = 7'd20;
  localparam logic [7:0] RUN_RST      = 8'd5;

  localparam int          RESULT_CAP = 5;
  localparam logic [16:0] PCT_SCALE  = 17'd100;
  localparam logic [16:0] PCT_MAX    = 17'd100;
  localparam logic [15:0] SECS_MAX   = 16'hFFFF;

  // Divider geometry: dividend holds |raw - wet| * 100, divisor holds |dry - wet|.
  localparam int DVW = 17;
  localparam int DSW = 10;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_SAMPLE = 3'd1,
    REQ_CHECK  = 3'd2,
    REQ_SET    = 3'd3,
    REQ_PUMP   = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_MOIST   = 3'd1,
    EV_RAW     = 3'd2,
    EV_STARTED = 3'd3,
    EV_LIMIT   = 3'd4,
    EV_STOPPED = 3'd5
  } ev_t;

  typedef enum logic [1:0] {
    CFG_WET      = 2'd0,
    CFG_DRY      = 2'd1,
    CFG_COOLDOWN = 2'd2,
    CFG_LIMIT    = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_TICK_INC,
    OP_STOP,
    OP_MANUAL_START,
    OP_SET,
    OP_DIV_SAMPLE,
    OP_OOR,
    OP_WIN_WRITE,
    OP_SUM_STEP,
    OP_DIV_AVG,
    OP_AVG_STORE,
    OP_SCAN_INIT,
    OP_SCAN_STEP,
    OP_FINISH
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TICK_CHK,
    S_STOP,
    S_MANUAL,
    S_DIV_S,
    S_OOR,
    S_SUM,
    S_DIV_A,
    S_AVG_STORE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       ch_ok;
    logic       pump;
    logic       chk_ok;
    logic       den_zero;
    logic       div_done;
    logic       q_ok;
    logic       sum_done;
    logic       tick_stop;
    logic       scan_last;
    logic       out_free;
    logic       cmd_on;
  } dp_stat_t;

  // Remainder of a small value by a small count, by repeated subtraction.
  function automatic logic [2:0] mod_small(logic [2:0] v, int n);
    logic [3:0] r;
    r = {1'b0, v};
    for (int k = 0; k < 8; k++) begin
      if (r >= 4'(n)) begin
        r = r - 4'(n);
      end
    end
    return r[2:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mcic_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcic_in_if / mcic_out_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface mcic_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [2:0] channel;
  logic [9:0] raw_reading;
  logic [2:0] start_channel;
  logic [6:0] low_threshold;
  logic [7:0] run_seconds;
  logic       pump_cmd;

  modport source (output valid, req_type, channel, raw_reading, start_channel,
                  low_threshold, run_seconds, pump_cmd, input ready);
  modport sink (input valid, req_type, channel, raw_reading, start_channel,
                low_threshold, run_seconds, pump_cmd, output ready);
endinterface

interface mcic_out_if #(parameter int CH = 5);
  logic          valid;
  logic          ready;
  logic [2:0]    event_res;
  logic [2:0]    event_channel;
  logic [9:0]    moisture_value;
  logic [CH-1:0] relay_mask;
  logic          pumping;
  logic          last;

  modport source (output valid, event_res, event_channel, moisture_value,
                  relay_mask, pumping, last, input ready);
  modport sink (input valid, event_res, event_channel, moisture_value,
                relay_mask, pumping, last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/multi_channel_irrigation_controller_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_irrigation_controller_core
// Moisture averaging, pump timing and schedule scan for several channels.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake   | Word
// in_ch   | in  | valid/ready | request: tick, sample, check, set, pump
// out_ch  | out | valid/ready | event result, last flag ends a request
// cfg_*   | in  | write only  | calibration, cooldown, attempt limit
//
// One request at a time. An in-range sample runs the 17-step serial divider
// for the calibration mapping and then sweeps the window through the
// single-port read of the window memory. Synchronous active-low reset; no
// clearing pass, window entries carry valid bits. A stalled output holds the
// sequencer before each further result word.
// ----------------------------------------------------------------------------
module multi_channel_irrigation_controller_core #(
  parameter int CHANNELS = mcic_pkg::CHANNELS_DEF,
  parameter int WINDOW   = mcic_pkg::WINDOW_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  mcic_in_if.sink         in_ch,
  mcic_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_idx,
  input  wire logic [9:0] cfg_wdata
);
  import mcic_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mcic_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mcic_dp #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_req_type        (in_ch.req_type),
    .in_channel         (in_ch.channel),
    .in_raw_reading     (in_ch.raw_reading),
    .in_start_channel   (in_ch.start_channel),
    .in_low_threshold   (in_ch.low_threshold),
    .in_run_seconds     (in_ch.run_seconds),
    .in_pump_cmd        (in_ch.pump_cmd),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_event_res      (out_ch.event_res),
    .out_event_channel  (out_ch.event_channel),
    .out_moisture_value (out_ch.moisture_value),
    .out_relay_mask     (out_ch.relay_mask),
    .out_pumping        (out_ch.pumping),
    .out_last           (out_ch.last)
  );

endmodule
`default_nettype wire

@@ hw/rtl/mcic_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcic_ctrl
// Sequencer: decodes each request word and steps the datapath through it.
// ----------------------------------------------------------------------------
module mcic_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mcic_pkg::dp_stat_t stat,
  output mcic_pkg::dp_cmd_t      cmd
);
  import mcic_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        unique case (stat.req)
          REQ_TICK: begin
            cmd.op    = OP_TICK_INC;
            state_nxt = S_TICK_CHK;
          end
          REQ_SAMPLE: begin
            if (stat.ch_ok && !stat.pump) begin
              if (stat.den_zero) begin
                state_nxt = S_OOR;
              end else begin
                cmd.op    = OP_DIV_SAMPLE;
                state_nxt = S_DIV_S;
              end
            end
          end
          REQ_CHECK: begin
            if (stat.chk_ok) begin
              cmd.op    = OP_SCAN_INIT;
              state_nxt = S_SCAN;
            end
          end
          REQ_SET: begin
            if (stat.ch_ok) begin
              cmd.op = OP_SET;
            end
          end
          REQ_PUMP: begin
            if (!stat.cmd_on) begin
              state_nxt = S_STOP;
            end else if (stat.ch_ok) begin
              state_nxt = S_MANUAL;
            end
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_TICK_CHK: begin
        state_nxt = stat.tick_stop ? S_STOP : S_FINISH;
      end
      S_STOP: begin
        if (stat.out_free) begin
          cmd.op    = OP_STOP;
          state_nxt = S_FINISH;
        end
      end
      S_MANUAL: begin
        if (stat.out_free) begin
          cmd.op    = OP_MANUAL_START;
          state_nxt = S_FINISH;
        end
      end
      S_DIV_S: begin
        if (stat.div_done) begin
          if (stat.q_ok) begin
            cmd.op    = OP_WIN_WRITE;
            state_nxt = S_SUM;
          end else begin
            state_nxt = S_OOR;
          end
        end
      end
      S_OOR: begin
        if (stat.out_free) begin
          cmd.op    = OP_OOR;
          state_nxt = S_FINISH;
        end
      end
      S_SUM: begin
        if (stat.sum_done) begin
          cmd.op    = OP_DIV_AVG;
          state_nxt = S_DIV_A;
        end else begin
          cmd.op = OP_SUM_STEP;
        end
      end
      S_DIV_A: begin
        if (stat.div_done) begin
          state_nxt = S_AVG_STORE;
        end
      end
      S_AVG_STORE: begin
        if (stat.out_free) begin
          cmd.op    = OP_AVG_STORE;
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        if (stat.out_free) begin
          cmd.op = OP_SCAN_STEP;
          if (stat.scan_last) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.op    = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/mcic_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcic_dp
// Datapath: channel state, averaging window memory, serial divider, result
// staging and the output register.
// ----------------------------------------------------------------------------
module mcic_dp #(
  parameter int CHANNELS = mcic_pkg::CHANNELS_DEF,
  parameter int WINDOW   = mcic_pkg::WINDOW_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mcic_pkg::dp_cmd_t  cmd,
  output mcic_pkg::dp_stat_t      stat,
  input  wire logic [2:0]         in_req_type,
  input  wire logic [2:0]         in_channel,
  input  wire logic [9:0]         in_raw_reading,
  input  wire logic [2:0]         in_start_channel,
  input  wire logic [6:0]         in_low_threshold,
  input  wire logic [7:0]         in_run_seconds,
  input  wire logic               in_pump_cmd,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_idx,
  input  wire logic [9:0]         cfg_wdata,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_event_res,
  output logic [2:0]              out_event_channel,
  output logic [9:0]              out_moisture_value,
  output logic [CHANNELS-1:0]     out_relay_mask,
  output logic                    out_pumping,
  output logic                    out_last
);
  import mcic_pkg::*;

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SCW   = $clog2(WINDOW + 1);
  localparam int DEPTH = CHANNELS * WINDOW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $clog2(WINDOW * 100 + 1);

  // The window mean is the sum times a scaled reciprocal of WINDOW. With 20
  // fraction bits the rounding error stays far below 1/WINDOW for any sum.
  localparam int RK  = 20;
  localparam int MW  = RK + 1;
  localparam int PRW = RK + SW + 1;
  localparam logic [MW-1:0] AVG_MUL = MW'((1 << RK) / WINDOW + 1);

  // Configuration.
  logic [9:0] wet_r, dry_r;
  logic [7:0] cool_r;
  logic [3:0] limit_r;

  // Latched request word.
  logic [2:0] req_r, ch_r, start_r;
  logic [9:0] raw_r;
  logic [6:0] thr_in_r;
  logic [7:0] run_in_r;
  logic       cmd_r;

  // Channel state.
  logic [9:0]          moist_r [CHANNELS];
  logic [6:0]          thr_r   [CHANNELS];
  logic [7:0]          run_r   [CHANNELS];
  logic [4:0]          cnt_r   [CHANNELS];
  logic [PW-1:0]       ptr_r   [CHANNELS];
  logic [CHANNELS-1:0] relay_r;
  logic                pump_r;
  logic [CW-1:0]       active_r;
  logic [15:0]         secs_r;
  logic [CW-1:0]       sel_r;
  logic [CW-1:0]       scan_j_r;

  // Window memory and its per-entry valid bits.
  logic [6:0]       win_mem [DEPTH];
  logic [DEPTH-1:0] win_vld_r;
  logic [6:0]       rdata_r;
  logic             rvld_r;
  logic [SCW-1:0]   scnt_r;
  logic             rdv_r;
  logic [SW-1:0]    sum_r;

  // Serial divider.
  logic [DVW-1:0] dvd_r;
  logic [DSW-1:0] dsr_r;
  logic [DSW-1:0] rem_r;
  logic           neg_r;
  logic           div_busy_r;
  logic [4:0]     div_cnt_r;

  // Result staging.
  logic                pend_v_r;
  logic [2:0]          pend_ev_r, pend_ch_r;
  logic [9:0]          pend_val_r;
  logic [CHANNELS-1:0] pend_relay_r;
  logic                pend_pump_r;
  logic [2:0]          ev_cnt_r;
  logic                out_v_r;

  // ------------------------------------------------------------------
  // Combinational datapath.
  // ------------------------------------------------------------------
  logic [9:0]          cur_m;
  logic [6:0]          cur_t;
  logic [4:0]          cur_a;
  logic                at_limit, try_start, do_start, wet_ok;
  logic [CHANNELS-1:0] relay_nxt;
  logic                pump_nxt;
  logic                rec_v;
  logic [2:0]          rec_ev, rec_ch;
  logic [9:0]          rec_val;
  logic                moist_we, cnt_we;
  logic [9:0]          moist_nxt;
  logic [4:0]          cnt_nxt;
  logic [10:0]         diff, dend;
  logic [9:0]          abs_diff, abs_den;
  logic [DVW-1:0]      num_mag;
  logic [DSW:0]        trial;
  logic [AW-1:0]       base, waddr, raddr;
  logic                rd_issue, out_free, record;
  logic [PRW-1:0]      avg_prod;

  assign cur_m     = moist_r[sel_r];
  assign cur_t     = thr_r[sel_r];
  assign cur_a     = cnt_r[sel_r];
  assign at_limit  = cur_a >= {1'b0, limit_r};
  assign wet_ok    = cur_m >= {3'b0, cur_t};
  assign try_start = !wet_ok && (cur_a <= {1'b0, limit_r});
  assign do_start  = (cmd.op == OP_MANUAL_START) || ((cmd.op == OP_SCAN_STEP) && try_start);

  assign diff     = {1'b0, raw_r} - {1'b0, wet_r};
  assign dend     = {1'b0, dry_r} - {1'b0, wet_r};
  assign abs_diff = diff[10] ? 10'(-diff) : diff[9:0];
  assign abs_den  = dend[10] ? 10'(-dend) : dend[9:0];
  assign num_mag  = {7'd0, abs_diff} * PCT_SCALE;
  assign trial    = {rem_r, dvd_r[DVW-1]};
  assign avg_prod = PRW'(sum_r) * PRW'(AVG_MUL);

  assign base     = AW'(sel_r) * AW'(WINDOW);
  assign waddr    = base + AW'(ptr_r[sel_r]);
  assign raddr    = base + AW'(scnt_r);
  assign rd_issue = (cmd.op == OP_SUM_STEP) && (scnt_r < SCW'(WINDOW));

  assign out_free = !out_v_r || out_ready;

  always_comb begin
    relay_nxt = relay_r;
    pump_nxt  = pump_r;
    rec_v     = 1'b0;
    rec_ev    = EV_NONE;
    rec_ch    = 3'(sel_r);
    rec_val   = cur_m;
    moist_we  = 1'b0;
    moist_nxt = cur_m;
    cnt_we    = 1'b0;
    cnt_nxt   = cur_a;
    case (cmd.op)
      OP_STOP: begin
        relay_nxt = '0;
        pump_nxt  = 1'b0;
        rec_v     = 1'b1;
        rec_ev    = EV_STOPPED;
        rec_ch    = 3'(active_r);
        rec_val   = '0;
      end
      OP_OOR: begin
        moist_we  = 1'b1;
        moist_nxt = raw_r;
        rec_v     = 1'b1;
        rec_ev    = EV_RAW;
        rec_val   = raw_r;
      end
      OP_AVG_STORE: begin
        moist_we  = 1'b1;
        moist_nxt = dvd_r[9:0];
        rec_v     = 1'b1;
        rec_ev    = EV_MOIST;
        rec_val   = dvd_r[9:0];
      end
      OP_SCAN_STEP: begin
        if (try_start) begin
          cnt_we  = 1'b1;
          cnt_nxt = cur_a + 5'd1;
        end
        if (wet_ok) begin
          cnt_we  = 1'b1;
          cnt_nxt = '0;
        end
      end
      default: ;
    endcase
    if (do_start) begin
      rec_v = 1'b1;
      if (at_limit) begin
        rec_ev = EV_LIMIT;
      end else begin
        relay_nxt = relay_r | (CHANNELS'(1) << sel_r);
        pump_nxt  = 1'b1;
        rec_ev    = EV_STARTED;
      end
    end
  end

  assign record = rec_v && (ev_cnt_r < 3'(RESULT_CAP));

  // ------------------------------------------------------------------
  // Configuration and request latch.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wet_r   <= WET_RAW_RST;
      dry_r   <= DRY_RAW_RST;
      cool_r  <= COOLDOWN_RST;
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_WET:      wet_r   <= cfg_wdata;
        CFG_DRY:      dry_r   <= cfg_wdata;
        CFG_COOLDOWN: cool_r  <= cfg_wdata[7:0];
        CFG_LIMIT:    limit_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      req_r    <= in_req_type;
      ch_r     <= in_channel;
      raw_r    <= in_raw_reading;
      start_r  <= in_start_channel;
      thr_in_r <= in_low_threshold;
      run_in_r <= in_run_seconds;
      cmd_r    <= in_pump_cmd;
    end
  end

  // ------------------------------------------------------------------
  // Channel and pump state.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        moist_r[i] <= MOIST_RST;
        thr_r[i]   <= THR_RST;
        run_r[i]   <= RUN_RST;
        cnt_r[i]   <= '0;
        ptr_r[i]   <= '0;
      end
      relay_r  <= '0;
      pump_r   <= 1'b0;
      active_r <= '0;
      secs_r   <= '0;
      sel_r    <= '0;
      scan_j_r <= '0;
    end else begin
      relay_r <= relay_nxt;
      pump_r  <= pump_nxt;
      if (moist_we) begin
        moist_r[sel_r] <= moist_nxt;
      end
      if (cnt_we) begin
        cnt_r[sel_r] <= cnt_nxt;
      end
      if (do_start && !at_limit) begin
        active_r <= sel_r;
        secs_r   <= '0;
      end
      case (cmd.op)
        OP_LATCH: begin
          sel_r <= (in_req_type == REQ_TICK) ? active_r : CW'(in_channel);
        end
        OP_TICK_INC: begin
          if (secs_r != SECS_MAX) begin
            secs_r <= secs_r + 16'd1;
          end
        end
        OP_SET: begin
          thr_r[sel_r] <= thr_in_r;
          run_r[sel_r] <= run_in_r;
          cnt_r[sel_r] <= '0;
        end
        OP_AVG_STORE: begin
          ptr_r[sel_r] <= (ptr_r[sel_r] == PW'(WINDOW - 1)) ? '0 : ptr_r[sel_r] + PW'(1);
        end
        OP_SCAN_INIT: begin
          sel_r    <= CW'(mod_small(start_r, CHANNELS));
          scan_j_r <= '0;
        end
        OP_SCAN_STEP: begin
          sel_r    <= (sel_r == CW'(CHANNELS - 1)) ? '0 : sel_r + CW'(1);
          scan_j_r <= scan_j_r + CW'(1);
        end
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Window memory: one write, one registered read per cycle.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WIN_WRITE) begin
      win_mem[waddr] <= dvd_r[6:0];
    end
    rdata_r <= win_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_vld_r <= '0;
      rvld_r    <= 1'b0;
      scnt_r    <= '0;
      rdv_r     <= 1'b0;
      sum_r     <= '0;
    end else begin
      rvld_r <= win_vld_r[raddr];
      if (cmd.op == OP_WIN_WRITE) begin
        win_vld_r[waddr] <= 1'b1;
        scnt_r           <= '0;
        rdv_r            <= 1'b0;
        sum_r            <= '0;
      end else if (cmd.op == OP_SUM_STEP) begin
        rdv_r <= rd_issue;
        if (rd_issue) begin
          scnt_r <= scnt_r + SCW'(1);
        end
        if (rdv_r && rvld_r) begin
          sum_r <= sum_r + SW'(rdata_r);
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Restoring divider for the calibration mapping, one quotient bit per
  // cycle. The window mean is loaded in one step from the reciprocal
  // product and leaves the divider idle.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (cmd.op == OP_DIV_SAMPLE) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= 5'(DVW);
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r - 5'd1;
      if (div_cnt_r == 5'd1) begin
        div_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIV_SAMPLE) begin
      dvd_r <= num_mag;
      dsr_r <= abs_den;
      rem_r <= '0;
      neg_r <= diff[10] ^ dend[10];
    end else if (cmd.op == OP_DIV_AVG) begin
      dvd_r <= DVW'(avg_prod[RK +: SW]);
      neg_r <= 1'b0;
    end else if (div_busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_r <= DSW'(trial - {1'b0, dsr_r});
        dvd_r <= {dvd_r[DVW-2:0], 1'b1};
      end else begin
        rem_r <= trial[DSW-1:0];
        dvd_r <= {dvd_r[DVW-2:0], 1'b0};
      end
    end
  end

  // ------------------------------------------------------------------
  // Result staging: the newest event waits in a pending slot so that the
  // final word of a request can carry the last flag.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      ev_cnt_r <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (cmd.op == OP_FINISH) begin
        out_v_r  <= 1'b1;
        pend_v_r <= 1'b0;
        ev_cnt_r <= '0;
      end else if (record) begin
        if (pend_v_r) begin
          out_v_r <= 1'b1;
        end
        pend_v_r <= 1'b1;
        ev_cnt_r <= ev_cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (record) begin
      pend_ev_r    <= rec_ev;
      pend_ch_r    <= rec_ch;
      pend_val_r   <= rec_val;
      pend_relay_r <= relay_nxt;
      pend_pump_r  <= pump_nxt;
    end
    if (cmd.op == OP_FINISH) begin
      out_last <= 1'b1;
      if (pend_v_r) begin
        out_event_res      <= pend_ev_r;
        out_event_channel  <= pend_ch_r;
        out_moisture_value <= pend_val_r;
        out_relay_mask     <= pend_relay_r;
        out_pumping        <= pend_pump_r;
      end else begin
        out_event_res      <= EV_NONE;
        out_event_channel  <= '0;
        out_moisture_value <= '0;
        out_relay_mask     <= relay_r;
        out_pumping        <= pump_r;
      end
    end else if (record && pend_v_r) begin
      out_last           <= 1'b0;
      out_event_res      <= pend_ev_r;
      out_event_channel  <= pend_ch_r;
      out_moisture_value <= pend_val_r;
      out_relay_mask     <= pend_relay_r;
      out_pumping        <= pend_pump_r;
    end
  end

  assign out_valid = out_v_r;

  // ------------------------------------------------------------------
  // Status to the sequencer.
  // ------------------------------------------------------------------
  assign stat.req       = req_r;
  assign stat.ch_ok     = {1'b0, ch_r} < 4'(CHANNELS);
  assign stat.pump      = pump_r;
  assign stat.chk_ok    = !pump_r && (secs_r >= {8'd0, cool_r});
  assign stat.den_zero  = (wet_r == dry_r);
  assign stat.div_done  = !div_busy_r;
  assign stat.q_ok      = (dvd_r <= PCT_MAX) && (!neg_r || dvd_r == '0);
  assign stat.sum_done  = (scnt_r == SCW'(WINDOW)) && !rdv_r;
  assign stat.tick_stop = pump_r && (secs_r >= {8'd0, run_r[sel_r]});
  assign stat.scan_last = (scan_j_r == CW'(CHANNELS - 1));
  assign stat.out_free  = out_free;
  assign stat.cmd_on    = cmd_r;

`ifndef SYNTHESIS
  a_ev_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ev_cnt_r <= 3'(RESULT_CAP))
    else $error("event count beyond result cap");
  a_pend_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (ev_cnt_r != 3'd0))
    else $error("pending event without count");
  a_relay_pump: assert property (@(posedge clk) disable iff (!rst_n)
    (relay_r != '0) == pump_r)
    else $error("relay mask and pump flag disagree");
  a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FINISH) |=> (!pend_v_r && out_v_r))
    else $error("final word not staged");
`endif

endmodule
`default_nettype wire
